// ===== hw/rtl/rrbm_pkg.sv =====
// rrbm_pkg: shared constants, types and helper functions for the record ring
// buffer manager. No dependencies.
package rrbm_pkg;

    localparam int RING_BYTES  = 4096;
    localparam int ALIGN_BYTES = 8;
    localparam int HDR_BYTES   = 8;
    localparam int SLOT_COUNT  = RING_BYTES / ALIGN_BYTES;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int ALIGN_W     = $clog2(ALIGN_BYTES);
    localparam int TRY_W       = $clog2(SLOT_COUNT + 2);
    localparam int POS_W       = 32;
    localparam int OFS_W       = 12;
    localparam int SIZE_W      = 12;
    localparam int LEN_W       = SIZE_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] RING_MASK = POS_W'(RING_BYTES - 1);
    localparam logic [LEN_W-1:0] LEN_ADD   = LEN_W'(HDR_BYTES + ALIGN_BYTES - 1);

    typedef enum logic [2:0] {
        OP_RESERVE     = 3'd0,
        OP_COMMIT      = 3'd1,
        OP_DISCARD     = 3'd2,
        OP_READ_BEGIN  = 3'd3,
        OP_READ        = 3'd4,
        OP_READ_END    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_PENDING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RES_CHK,
        S_REL_WR,
        S_WALK_CHK,
        S_WALK_HDR,
        S_MISC
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [SIZE_W-1:0] req;
        logic [OFS_W-1:0]  roff;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_bus;

    typedef struct packed {
        logic              busy;
        logic              discard;
        logic [SIZE_W-1:0] size;
    } t_header;

    localparam int HDR_W = $bits(t_header);

    // header plus payload, rounded up to the alignment
    function automatic logic [LEN_W-1:0] align_len(input logic [SIZE_W-1:0] size);
        logic [LEN_W-1:0] sum;
        sum = {1'b0, size} + LEN_ADD;
        return {sum[LEN_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
    endfunction

    function automatic logic [OFS_W-1:0] ring_off(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] m;
        m = pos & RING_MASK;
        return m[OFS_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] m;
        m = pos & RING_MASK;
        return m[SLOT_W+ALIGN_W-1:ALIGN_W];
    endfunction

endpackage

// ===== hw/rtl/rrbm_front.sv =====
// rrbm_front: takes commands off the start/busy port, drops unknown op codes
// and hands the rest to the command queue. Depends on rrbm_pkg.
module rrbm_front (
    input  logic                      start,
    input  logic                      i_queue_full,
    input  logic [2:0]                i_op,
    input  logic [rrbm_pkg::SIZE_W-1:0] i_request_size,
    input  logic [rrbm_pkg::OFS_W-1:0]  i_record_offset,
    output logic                      busy,
    output rrbm_pkg::t_cmd_bus        o_push
);
    import rrbm_pkg::*;

    logic known;
    t_op  op_dec;

    always_comb begin
        known  = 1'b1;
        op_dec = OP_RESERVE;
        unique case (i_op)
            3'(OP_RESERVE):    op_dec = OP_RESERVE;
            3'(OP_COMMIT):     op_dec = OP_COMMIT;
            3'(OP_DISCARD):    op_dec = OP_DISCARD;
            3'(OP_READ_BEGIN): op_dec = OP_READ_BEGIN;
            3'(OP_READ):       op_dec = OP_READ;
            3'(OP_READ_END):   op_dec = OP_READ_END;
            default:           known  = 1'b0;
        endcase
    end

    assign busy            = i_queue_full;
    // unknown codes are taken and silently dropped
    assign o_push.valid    = start && !i_queue_full && known;
    assign o_push.cmd.op   = op_dec;
    assign o_push.cmd.req  = i_request_size;
    assign o_push.cmd.roff = i_record_offset;

endmodule

// ===== hw/rtl/rrbm_queue.sv =====
// rrbm_queue: short command queue between the front and back parts.
// Depends on rrbm_pkg.
module rrbm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrbm_pkg::t_cmd_bus i_push,
    input  logic               i_pop,
    output rrbm_pkg::t_cmd_bus o_head,
    output logic               o_full
);
    import rrbm_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign do_push = i_push.valid;
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.cmd;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_slot[r_rd_ptr];
    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));

endmodule

// ===== hw/rtl/rrbm_back.sv =====
// rrbm_back: executes queued commands against the ring positions and the
// header store, and drives the registered result port. Depends on rrbm_pkg.
module rrbm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rrbm_pkg::t_cmd_bus          i_head,
    output logic                        o_pop,
    output logic                        o_strobe,
    output logic [1:0]                  o_status,
    output logic [rrbm_pkg::OFS_W-1:0]  o_header_offset,
    output logic [rrbm_pkg::OFS_W-1:0]  o_payload_offset,
    output logic [rrbm_pkg::SIZE_W-1:0] o_record_size
);
    import rrbm_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [POS_W-1:0]  r_wp, n_wp;
    logic [POS_W-1:0]  r_rp, n_rp;
    logic [POS_W-1:0]  r_cp, n_cp;
    logic [POS_W-1:0]  r_lim, n_lim;
    logic [POS_W-1:0]  r_next, n_next;
    logic [TRY_W-1:0]  r_tries, n_tries;

    logic              r_strobe, n_strobe;
    t_status           r_status, n_status;
    logic [OFS_W-1:0]  r_hoff, n_hoff;
    logic [OFS_W-1:0]  r_poff, n_poff;
    logic [SIZE_W-1:0] r_size, n_size;

    logic [HDR_W-1:0]  mem [SLOT_COUNT];
    logic [HDR_W-1:0]  r_rd_data;
    logic              mem_re, mem_we;
    logic [SLOT_W-1:0] mem_ra, mem_wa;
    t_header           mem_wd;

    t_header           hdr;
    logic              walk_stop;
    logic              res_full;
    logic [POS_W-1:0]  ahead;

    assign hdr       = t_header'(r_rd_data);
    assign walk_stop = (r_tries > TRY_W'(SLOT_COUNT)) || (r_cp == r_lim);
    assign res_full  = (r_next - r_rp) > RING_MASK;
    assign ahead     = r_cp - r_rp;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    case (i_head.cmd.op) inside
                        OP_RESERVE:             n_state = S_RES_CHK;
                        OP_COMMIT, OP_DISCARD:  n_state = S_REL_WR;
                        OP_READ:                n_state = S_WALK_CHK;
                        default:                n_state = S_MISC;
                    endcase
                end
            end
            S_RES_CHK:  n_state = S_IDLE;
            S_REL_WR:   n_state = S_IDLE;
            S_WALK_CHK: n_state = walk_stop ? S_IDLE : S_WALK_HDR;
            S_WALK_HDR: begin
                // discarded records are skipped, the walk goes on
                if (!hdr.busy && hdr.discard) begin
                    n_state = S_WALK_CHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MISC:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd    = r_cmd;
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_cp     = r_cp;
        n_lim    = r_lim;
        n_next   = r_next;
        n_tries  = r_tries;
        n_strobe = 1'b0;
        n_status = ST_OK;
        n_hoff   = '0;
        n_poff   = '0;
        n_size   = '0;
        o_pop    = 1'b0;
        mem_re   = 1'b0;
        mem_ra   = slot_of(r_cp);
        mem_we   = 1'b0;
        mem_wa   = slot_of(POS_W'(r_cmd.roff));
        mem_wd   = hdr;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_head.cmd;
                    n_tries = '0;
                    n_next  = r_wp + POS_W'(align_len(i_head.cmd.req));
                    mem_re  = (i_head.cmd.op == OP_COMMIT) ||
                              (i_head.cmd.op == OP_DISCARD);
                    mem_ra  = slot_of(POS_W'(i_head.cmd.roff));
                end
            end
            S_RES_CHK: begin
                n_strobe = 1'b1;
                if (res_full) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we       = 1'b1;
                    mem_wa       = slot_of(r_wp);
                    mem_wd.busy    = 1'b1;
                    mem_wd.discard = 1'b0;
                    mem_wd.size    = r_cmd.req;
                    n_wp   = r_next;
                    n_hoff = ring_off(r_wp);
                    n_poff = ring_off(r_wp + POS_W'(HDR_BYTES));
                    n_size = r_cmd.req;
                end
            end
            S_REL_WR: begin
                n_strobe       = 1'b1;
                mem_we         = 1'b1;
                mem_wd.busy    = 1'b0;
                mem_wd.discard = hdr.discard || (r_cmd.op == OP_DISCARD);
            end
            S_WALK_CHK: begin
                if (walk_stop) begin
                    n_strobe = 1'b1;
                    n_status = ST_EMPTY;
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_WALK_HDR: begin
                if (hdr.busy) begin
                    n_strobe = 1'b1;
                    n_status = ST_PENDING;
                end else begin
                    n_cp    = r_cp + POS_W'(align_len(hdr.size));
                    n_tries = r_tries + 1'b1;
                    if (!hdr.discard) begin
                        n_strobe = 1'b1;
                        n_hoff   = ring_off(r_cp);
                        n_poff   = ring_off(r_cp + POS_W'(HDR_BYTES));
                        n_size   = hdr.size;
                    end
                end
            end
            S_MISC: begin
                n_strobe = 1'b1;
                if (r_cmd.op == OP_READ_BEGIN) begin
                    n_lim = r_wp;
                end else if ((ahead != '0) && !ahead[POS_W-1]) begin
                    // release only moves forward
                    n_rp = r_cp;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_rp     <= '0;
            r_cp     <= '0;
            r_lim    <= '0;
            r_tries  <= '0;
            r_strobe <= 1'b0;
            r_status <= ST_OK;
            r_hoff   <= '0;
            r_poff   <= '0;
            r_size   <= '0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_cp     <= n_cp;
            r_lim    <= n_lim;
            r_tries  <= n_tries;
            r_strobe <= n_strobe;
            r_status <= n_status;
            r_hoff   <= n_hoff;
            r_poff   <= n_poff;
            r_size   <= n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_next <= n_next;
    end

    // header store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_header_offset  = r_hoff;
    assign o_payload_offset = r_poff;
    assign o_record_size    = r_size;

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status != ST_OK) |->
            (r_hoff == '0 && r_poff == '0 && r_size == '0))
        else $error("non-ok result carries nonzero fields");

    a_pos_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp[ALIGN_W-1:0] == '0) && (r_cp[ALIGN_W-1:0] == '0))
        else $error("write or consume position lost alignment");

    a_release_to_consume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_rp != $past(r_rp)) |-> (r_rp == $past(r_cp)))
        else $error("release position moved somewhere other than consume position");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tries <= TRY_W'(SLOT_COUNT + 1))
        else $error("read walk exceeded its header bound");

endmodule

// ===== hw/rtl/record_ring_buffer_manager.sv =====
// record_ring_buffer_manager: top level, front decode, command queue and
// back-end executor. Depends on rrbm_pkg, rrbm_front, rrbm_queue, rrbm_back.
//
// Commands are taken when start is high and busy is low; busy rises only
// when the two-entry command queue is full. Each command with op 0..5 gives
// exactly one result, shown for one cycle with o_strobe high, and the
// receiver cannot stall it; op codes 6 and 7 are taken and give no result.
// The back end handles one command at a time against a single-port header
// store with registered read data: reserve, commit, discard, read begin and
// read end go from idle to one execute state. A read goes from idle to the
// walk check, which stops at once at the snapshot or reads a header; the
// header state returns a record, stops at a busy header or skips a discarded
// one and walks on, bounded by 513 headers (one per slot plus one).
// The header store has no reset; a header that was never written must not
// be read.
module record_ring_buffer_manager (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_op,
    input  logic [rrbm_pkg::SIZE_W-1:0] i_request_size,
    input  logic [rrbm_pkg::OFS_W-1:0]  i_record_offset,
    output logic                        o_strobe,
    output logic [1:0]                  o_status,
    output logic [rrbm_pkg::OFS_W-1:0]  o_header_offset,
    output logic [rrbm_pkg::OFS_W-1:0]  o_payload_offset,
    output logic [rrbm_pkg::SIZE_W-1:0] o_record_size
);
    import rrbm_pkg::*;

    t_cmd_bus push;
    t_cmd_bus head;
    logic     queue_full;
    logic     pop;

    rrbm_front u_front (
        .start           (start),
        .i_queue_full    (queue_full),
        .i_op            (i_op),
        .i_request_size  (i_request_size),
        .i_record_offset (i_record_offset),
        .busy            (busy),
        .o_push          (push)
    );

    rrbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (queue_full)
    );

    rrbm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .o_pop            (pop),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_header_offset  (o_header_offset),
        .o_payload_offset (o_payload_offset),
        .o_record_size    (o_record_size)
    );

endmodule
